// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect signals named clk and rst_n in the enclosing scope.
`define CHK_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/lssm_pkg.sv -----
package lssm_pkg;

  localparam int NVAR_DEF  = 16;
  localparam int NX_DEF    = 8;
  localparam int NSHK_DEF  = 4;

  localparam int LANES     = 4;
  localparam int LANE_BITS = 2;
  localparam int SHK_PORTS = 4;
  localparam int SHK_IW    = 2;
  localparam int GRP_W     = 4;
  localparam int ACC_W     = 56;
  localparam int Q_W       = 32;
  localparam int VIDX_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int DRAIN_CYC = 4;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] TBL_IMPACT = 2'd0;
  localparam logic [1:0] TBL_PROP   = 2'd1;
  localparam logic [1:0] TBL_SHARE  = 2'd2;
  localparam logic [1:0] TBL_STEADY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_STATE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_OFFSET = 2'd2;

  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [GRP_W-1:0] grp;
  } lane_ctl_t;

  typedef struct packed {
    logic                  vld;
    logic [GRP_W-1:0]      grp;
    logic signed [Q_W-1:0] row;
  } lane_res_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [Q_W-1:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[Q_W-1:0];
    end
    return r;
  endfunction

  // Rounds a Q32.32 product to Q32.16, ties toward plus infinity.
  function automatic logic signed [47:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return signed'(t[63:16]);
  endfunction

endpackage

// ----- hw/rtl/lssm_lane.sv -----
module lssm_lane #(
  parameter int NC  = 12,
  parameter int RPL = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lssm_pkg::lane_ctl_t           ctl,
  input  logic [$clog2(RPL*NC)-1:0]     raddr,
  input  logic signed [31:0]            opnd,
  input  logic                          cwe,
  input  logic [$clog2(RPL*NC)-1:0]     cwaddr,
  input  logic signed [31:0]            cwdata,
  input  logic                          ywe,
  input  logic [(RPL>1 ? $clog2(RPL) : 1)-1:0] ywaddr,
  input  logic signed [31:0]            ywdata,
  input  logic [(RPL>1 ? $clog2(RPL) : 1)-1:0] res_addr,
  output logic signed [31:0]            res_value,
  output lssm_pkg::lane_res_t           done
);
  import lssm_pkg::*;

  localparam int GW = (RPL > 1) ? $clog2(RPL) : 1;

  logic signed [Q_W-1:0]   cmem [RPL*NC];
  logic signed [Q_W-1:0]   ys [RPL];
  logic signed [Q_W-1:0]   res [RPL];
  logic signed [Q_W-1:0]   coef_r;
  logic signed [63:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [Q_W-1:0]   row_r;
  logic signed [Q_W-1:0]   ys_r;
  lane_ctl_t               ctl1_r, ctl2_r, ctl3_r, ctl4_r;

  always_ff @(posedge clk) begin
    if (cwe) begin
      cmem[cwaddr] <= cwdata;
    end
    coef_r <= cmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ywe) begin
      ys[ywaddr] <= ywdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  always_comb begin
    acc_nxt = (ctl2_r.first ? '0 : acc_r) + ACC_W'(qround(prod_r));
  end

  always_ff @(posedge clk) begin
    prod_r <= coef_r * opnd;
    if (ctl2_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (ctl3_r.vld && ctl3_r.last) begin
      row_r <= sat32(64'(acc_r));
      ys_r  <= ys[ctl3_r.grp[GW-1:0]];
    end
    if (ctl4_r.vld && ctl4_r.last) begin
      res[ctl4_r.grp[GW-1:0]] <= sat32(64'(row_r) + 64'(ys_r));
    end
  end

  assign res_value = res[res_addr];
  assign done.vld  = ctl4_r.vld & ctl4_r.last;
  assign done.grp  = ctl4_r.grp;
  assign done.row  = row_r;

endmodule

// ----- hw/rtl/lssm_merge.sv -----
module lssm_merge #(
  parameter int NVAR = 16,
  parameter int NX   = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  output logic [(NX>1 ? $clog2(NX) : 1)-1:0] sh_idx,
  input  logic signed [31:0]                 sh_state,
  input  logic                               gwe,
  input  logic [(NX>1 ? $clog2(NX) : 1)-1:0] gwaddr,
  input  logic signed [31:0]                 gwdata,
  input  logic signed [31:0]                 share_offset,
  input  logic signed [31:0]                 share_scale,
  output logic [$clog2(NVAR+1)-1:0]          e_idx,
  input  logic signed [31:0]                 rd_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lssm_pkg::VIDX_W-1:0]        out_var_index,
  output logic signed [31:0]                 out_value,
  output logic                               out_last
);
  import lssm_pkg::*;

  localparam int XW = (NX > 1) ? $clog2(NX) : 1;
  localparam int EW = $clog2(NVAR + 1);

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_SHARE = 3'd1;
  localparam logic [2:0] M_DRAIN = 3'd2;
  localparam logic [2:0] M_OFS   = 3'd3;
  localparam logic [2:0] M_MUL   = 3'd4;
  localparam logic [2:0] M_RND   = 3'd5;
  localparam logic [2:0] M_EMIT  = 3'd6;

  logic [2:0]              state_r;
  logic [XW-1:0]           idx_r;
  logic [EW-1:0]           e_r;
  logic                    p_vld_r;
  logic signed [Q_W-1:0]   gamma [NX];
  logic signed [63:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [Q_W-1:0]   s_r;
  logic signed [Q_W-1:0]   share_r;
  logic                    ov_r;
  logic                    ld;

  assign ld = (state_r == M_EMIT) && (!ov_r || !out_stall);

  always_ff @(posedge clk) begin
    if (gwe) begin
      gamma[gwaddr] <= gwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      idx_r   <= '0;
      e_r     <= '0;
      p_vld_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      p_vld_r <= (state_r == M_SHARE);
      if (ld) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        M_IDLE: begin
          if (start) begin
            state_r <= M_SHARE;
            idx_r   <= '0;
          end
        end
        M_SHARE: begin
          if (int'(idx_r) == NX - 1) begin
            state_r <= M_DRAIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        M_DRAIN: state_r <= M_OFS;
        M_OFS:   state_r <= M_MUL;
        M_MUL:   state_r <= M_RND;
        M_RND: begin
          state_r <= M_EMIT;
          e_r     <= '0;
        end
        M_EMIT: begin
          if (ld) begin
            if (e_r == EW'(NVAR)) begin
              state_r <= M_IDLE;
            end else begin
              e_r <= e_r + 1'b1;
            end
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == M_IDLE && start) begin
      acc_r <= '0;
    end else if (p_vld_r) begin
      acc_r <= acc_r + ACC_W'(qround(prod_r));
    end
    if (state_r == M_SHARE) begin
      prod_r <= sh_state * gamma[idx_r];
    end else if (state_r == M_MUL) begin
      prod_r <= s_r * share_scale;
    end
    if (state_r == M_OFS) begin
      s_r <= sat32(64'(acc_r) + 64'(share_offset));
    end
    if (state_r == M_RND) begin
      share_r <= sat32(64'(qround(prod_r)));
    end
    if (ld) begin
      out_var_index <= VIDX_W'(e_r);
      out_value     <= (e_r == EW'(NVAR)) ? share_r : rd_value;
      out_last      <= (e_r == EW'(NVAR));
    end
  end

  assign busy      = (state_r != M_IDLE);
  assign sh_idx    = idx_r;
  assign e_idx     = e_r;
  assign out_valid = ov_r;

endmodule

// ----- hw/rtl/linear_state_space_sim_step.sv -----
// Linear state-space step in signed Q16.16. Coefficients are written with load items
// and a restart item clears the state. A shock item is worked first by the four
// multiply-accumulate lanes, each of which works through its share of the variable rows
// one coefficient per cycle from its own coefficient memory, then by the single
// multiplier of the share unit, and last by one result per cycle on the output while
// out_stall is low. Results come out in variable order with the share last, marked by
// out_last.
module linear_state_space_sim_step #(
  parameter int NVAR = lssm_pkg::NVAR_DEF,
  parameter int NX   = lssm_pkg::NX_DEF,
  parameter int NSHK = lssm_pkg::NSHK_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic signed [31:0]                 in_shock_0,
  input  logic signed [31:0]                 in_shock_1,
  input  logic signed [31:0]                 in_shock_2,
  input  logic signed [31:0]                 in_shock_3,
  input  logic [1:0]                         in_table_select,
  input  logic [3:0]                         in_coef_row,
  input  logic [2:0]                         in_coef_col,
  input  logic signed [31:0]                 in_coef_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lssm_pkg::VIDX_W-1:0]        out_var_index,
  output logic signed [31:0]                 out_value,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [lssm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import lssm_pkg::*;

  localparam int NC  = NX + NSHK;
  localparam int RPL = (NVAR + LANES - 1) / LANES;
  localparam int GW  = (RPL > 1) ? $clog2(RPL) : 1;
  localparam int KW  = $clog2(NC);
  localparam int XW  = (NX > 1) ? $clog2(NX) : 1;
  localparam int AW  = $clog2(RPL * NC);
  localparam int EW  = $clog2(NVAR + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RUN    = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;

  logic [2:0]            state_r;
  logic [GW-1:0]         grp_r;
  logic [KW-1:0]         k_r;
  logic [2:0]            drain_r;
  logic [3:0]            state_offset_r;
  logic signed [Q_W-1:0] share_scale_r;
  logic signed [Q_W-1:0] share_offset_r;
  logic signed [Q_W-1:0] shock_r [SHK_PORTS];
  logic signed [Q_W-1:0] prev_state_r [NX];
  logic signed [Q_W-1:0] next_state_r [NX];
  logic signed [Q_W-1:0] next_state_nxt [NX];
  logic signed [Q_W-1:0] opnd;
  logic signed [Q_W-1:0] opnd_r;
  lane_ctl_t             ctl;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         cwaddr;
  logic [GW-1:0]         rgrp;
  logic                  accept;
  logic                  ld;
  logic                  ld_coef;
  logic                  merge_busy;
  logic [XW-1:0]         sh_idx;
  logic [EW-1:0]         e_idx;
  logic signed [Q_W-1:0] res_w [LANES];
  lane_res_t             done_w [LANES];

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ld       = accept && (in_op == OP_LOAD);
  assign rgrp     = GW'(in_coef_row >> LANE_BITS);

  always_comb begin
    ld_coef = 1'b0;
    cwaddr  = AW'(int'(rgrp) * NC + int'(in_coef_col));
    if (in_table_select == TBL_IMPACT) begin
      ld_coef = ld && int'(in_coef_row) < NVAR && int'(in_coef_col) < NSHK;
      cwaddr  = AW'(int'(rgrp) * NC + NX + int'(in_coef_col));
    end else if (in_table_select == TBL_PROP) begin
      ld_coef = ld && int'(in_coef_row) < NVAR && int'(in_coef_col) < NX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_offset_r <= '0;
      share_scale_r  <= 32'sd65536;
      share_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STATE_OFFSET: state_offset_r <= cfg_data[3:0];
        REG_SHARE_SCALE:  share_scale_r  <= signed'(cfg_data);
        REG_SHARE_OFFSET: share_offset_r <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      grp_r   <= '0;
      k_r     <= '0;
      drain_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept && in_op == OP_STEP) begin
            state_r <= S_RUN;
            grp_r   <= '0;
            k_r     <= '0;
          end
        end
        S_RUN: begin
          if (int'(k_r) == NC - 1) begin
            k_r <= '0;
            if (int'(grp_r) == RPL - 1) begin
              state_r <= S_DRAIN;
              drain_r <= '0;
            end else begin
              grp_r <= grp_r + 1'b1;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (int'(drain_r) == DRAIN_CYC - 1) begin
            state_r <= S_COMMIT;
          end else begin
            drain_r <= drain_r + 1'b1;
          end
        end
        S_COMMIT: state_r <= S_WAIT;
        S_WAIT: begin
          if (!merge_busy) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_op == OP_STEP) begin
      shock_r[0] <= in_shock_0;
      shock_r[1] <= in_shock_1;
      shock_r[2] <= in_shock_2;
      shock_r[3] <= in_shock_3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NX; i++) begin
        prev_state_r[i] <= '0;
      end
    end else if (accept && in_op == OP_RESTART) begin
      for (int i = 0; i < NX; i++) begin
        prev_state_r[i] <= '0;
      end
    end else if (state_r == S_COMMIT) begin
      prev_state_r <= next_state_r;
    end
  end

  always_comb begin
    int s;
    s    = int'(k_r) - NX;
    opnd = '0;
    if (int'(k_r) < NX) begin
      opnd = prev_state_r[k_r[XW-1:0]];
    end else if (s < SHK_PORTS) begin
      opnd = shock_r[SHK_IW'(s)];
    end
  end

  always_ff @(posedge clk) begin
    opnd_r <= opnd;
  end

  assign ctl.vld   = (state_r == S_RUN);
  assign ctl.first = (k_r == '0);
  assign ctl.last  = (int'(k_r) == NC - 1);
  assign ctl.grp   = GRP_W'(grp_r);
  assign raddr     = AW'(int'(grp_r) * NC + int'(k_r));

  for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
    lssm_lane #(
      .NC  (NC),
      .RPL (RPL)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .raddr     (raddr),
      .opnd      (opnd_r),
      .cwe       (ld_coef && int'(in_coef_row[LANE_BITS-1:0]) == gl),
      .cwaddr    (cwaddr),
      .cwdata    (in_coef_value),
      .ywe       (ld && in_table_select == TBL_STEADY && int'(in_coef_row) < NVAR
                  && int'(in_coef_row[LANE_BITS-1:0]) == gl),
      .ywaddr    (rgrp),
      .ywdata    (in_coef_value),
      .res_addr  (GW'(e_idx >> LANE_BITS)),
      .res_value (res_w[gl]),
      .done      (done_w[gl])
    );
  end

  // Rows that fall in the predetermined slice are collected for the next period.
  always_comb begin
    int off;
    int j;
    off = (int'(state_offset_r) > NVAR - NX) ? NVAR - NX : int'(state_offset_r);
    next_state_nxt = next_state_r;
    for (int l = 0; l < LANES; l++) begin
      j = int'(done_w[l].grp) * LANES + l;
      if (done_w[l].vld && j < NVAR && j >= off && j - off < NX) begin
        next_state_nxt[XW'(j - off)] = done_w[l].row;
      end
    end
  end

  always_ff @(posedge clk) begin
    next_state_r <= next_state_nxt;
  end

  lssm_merge #(
    .NVAR (NVAR),
    .NX   (NX)
  ) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (state_r == S_COMMIT),
    .busy          (merge_busy),
    .sh_idx        (sh_idx),
    .sh_state      (prev_state_r[sh_idx]),
    .gwe           (ld && in_table_select == TBL_SHARE && int'(in_coef_row) < NX),
    .gwaddr        (XW'(in_coef_row)),
    .gwdata        (in_coef_value),
    .share_offset  (share_offset_r),
    .share_scale   (share_scale_r),
    .e_idx         (e_idx),
    .rd_value      (res_w[e_idx[LANE_BITS-1:0]]),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_var_index (out_var_index),
    .out_value     (out_value),
    .out_last      (out_last)
  );

endmodule

// ----- hw/rtl/lssm_checker.sv -----
`include "assert_macros.svh"

module lssm_checker #(
  parameter int NVAR = lssm_pkg::NVAR_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  in_op,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lssm_pkg::VIDX_W-1:0] out_var_index,
  input logic signed [31:0]          out_value,
  input logic                        out_last
);
  import lssm_pkg::*;

  `CHK_IMPLIES(a_last_is_share, out_valid && out_last, out_var_index == VIDX_W'(NVAR))
  `CHK_IMPLIES(a_share_is_last, out_valid && (out_var_index == VIDX_W'(NVAR)), out_last)
  `CHK_NEXT(a_step_blocks_input, in_valid && !in_stall && (in_op == OP_STEP), in_stall)
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_var_index))

endmodule

bind linear_state_space_sim_step lssm_checker #(.NVAR(NVAR)) u_lssm_checker (.*);

// ----- tb/tb_linear_state_space_sim_step.sv -----
module tb_linear_state_space_sim_step;
  timeunit 1ns;
  timeprecision 1ps;
  import lssm_pkg::*;

  localparam int NV = 16;
  localparam int NS = 8;
  localparam int NK = 4;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;

  typedef struct {
    logic [4:0]         vidx;
    logic signed [31:0] val;
    logic               lst;
  } level_t;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] s0, s1, s2, s3;
    logic [1:0]         sel;
    logic [3:0]         r;
    logic [2:0]         c;
    logic signed [31:0] v;
    bit                 chk;
    logic signed [31:0] exp0;
  } shock_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic signed [31:0] in_shock_0 = '0, in_shock_1 = '0, in_shock_2 = '0, in_shock_3 = '0;
  logic [1:0] in_table_select = '0;
  logic [3:0] in_coef_row = '0;
  logic [2:0] in_coef_col = '0;
  logic signed [31:0] in_coef_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VIDX_W-1:0] out_var_index;
  logic signed [31:0] out_value;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  linear_state_space_sim_step dut (.*);

  level_t levels_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_seq = 0;
  int hold_len = 0;

  logic [3:0] m_offset;
  logic signed [31:0] m_scale, m_shoff;
  logic signed [31:0] m_state[NS];
  logic signed [31:0] m_impact[NV*NK];
  logic signed [31:0] m_prop[NV*NS];
  logic signed [31:0] m_gamma[NS];
  logic signed [31:0] m_steady[NV];

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [31:0] clip32(longint x);
    if (x > longint'(QMAX)) return QMAX;
    if (x < longint'(QMIN)) return QMIN;
    return x[31:0];
  endfunction

  function automatic longint qprod(logic signed [31:0] a, logic signed [31:0] b);
    longint y;
    y = longint'(a) * longint'(b) + 64'sd32768;
    return y >>> 16;
  endfunction

  task automatic predict_levels(shock_item_t it);
    logic signed [31:0] u[NK];
    logic signed [31:0] row[NV];
    longint acc;
    int off;
    level_t e;
    case (it.op)
      OP_LOAD: begin
        case (it.sel)
          TBL_IMPACT: if (it.c < NK) m_impact[it.r*NK + it.c] = it.v;
          TBL_PROP:   m_prop[it.r*NS + it.c] = it.v;
          TBL_SHARE:  if (it.r < NS) m_gamma[it.r] = it.v;
          default:    m_steady[it.r] = it.v;
        endcase
      end
      OP_RESTART: foreach (m_state[k]) m_state[k] = '0;
      OP_STEP: begin
        u[0] = it.s0; u[1] = it.s1; u[2] = it.s2; u[3] = it.s3;
        for (int j = 0; j < NV; j++) begin
          acc = 0;
          for (int k = 0; k < NS; k++) acc += qprod(m_prop[j*NS + k], m_state[k]);
          for (int k = 0; k < NK; k++) acc += qprod(m_impact[j*NK + k], u[k]);
          row[j] = clip32(acc);
        end
        off = (m_offset > NV - NS) ? NV - NS : m_offset;
        acc = 0;
        for (int k = 0; k < NS; k++) begin
          m_state[k] = row[off + k];
          acc += qprod(m_state[k], m_gamma[k]);
        end
        acc = clip32(acc + longint'(m_shoff));
        acc = clip32(qprod(acc[31:0], m_scale));
        for (int j = 0; j < NV; j++) begin
          e.vidx = 5'(j);
          e.val = clip32(longint'(row[j]) + longint'(m_steady[j]));
          if (j == 0 && it.chk) e.val = it.exp0;
          e.lst = 1'b0;
          levels_q.push_back(e);
        end
        e.vidx = 5'(NV);
        e.val = acc[31:0];
        e.lst = 1'b1;
        levels_q.push_back(e);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(shock_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_op = it.op;
    in_shock_0 = it.s0; in_shock_1 = it.s1; in_shock_2 = it.s2; in_shock_3 = it.s3;
    in_table_select = it.sel;
    in_coef_row = it.r;
    in_coef_col = it.c;
    in_coef_value = it.v;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_levels(it);
  endtask

  task automatic drain_all();
    @(negedge clk);
    in_valid = 1'b0;
    while (levels_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_STATE_OFFSET: m_offset = d[3:0];
      REG_SHARE_SCALE:  m_scale = d;
      REG_SHARE_OFFSET: m_shoff = d;
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? QMAX : QMIN;
      default: return $signed($urandom_range(262143)) - 32'sd131072;
    endcase
  endfunction

  function automatic shock_item_t rand_item();
    shock_item_t it;
    int p;
    it = '{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0};
    it.s0 = rand_q(); it.s1 = rand_q(); it.s2 = rand_q(); it.s3 = rand_q();
    it.sel = 2'($urandom()); it.r = 4'($urandom()); it.c = 3'($urandom());
    it.v = $urandom_range(3) == 0 ? rand_q() : $signed($urandom_range(65535)) - 32'sd32768;
    p = $urandom_range(99);
    if (p < 22) it.op = OP_LOAD;
    else if (p < 28) it.op = OP_RESTART;
    else if (p < 31) it.op = OP_NOP;
    return it;
  endfunction

  always @(negedge clk) begin
    static int seen = 0;
    static int left = 0;
    if (hold_seq != seen) begin
      seen = hold_seq;
      left = hold_len;
    end
    if (left > 0) begin
      left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    level_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (levels_q.size() == 0) begin
        $error("unexpected result var_index=%0d value=%0d", out_var_index, out_value);
        errors++;
      end else begin
        e = levels_q.pop_front();
        if (out_var_index !== e.vidx) begin
          $error("var_index expected %0d actual %0d", e.vidx, out_var_index);
          errors++;
        end
        if (out_value !== e.val) begin
          $error("value expected %0d actual %0d", e.val, out_value);
          errors++;
        end
        if (out_last !== e.lst) begin
          $error("last expected %0d actual %0d", e.lst, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    shock_item_t it;
    shock_item_t dir_tbl[16];
    m_offset = 0; m_scale = 32'sd65536; m_shoff = 0;
    foreach (m_state[k]) m_state[k] = '0;
    dir_tbl[0]  = '{OP_LOAD, 0, 0, 0, 0, TBL_STEADY, 4'd0, 3'd0, QMAX, 1'b0, 0};
    dir_tbl[1]  = '{OP_LOAD, 0, 0, 0, 0, TBL_IMPACT, 4'd0, 3'd0, QMAX, 1'b0, 0};
    dir_tbl[2]  = '{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, QMAX};
    dir_tbl[3]  = '{OP_STEP, QMAX, QMAX, QMAX, QMAX, 0, 0, 0, 0, 1'b0, 0};
    dir_tbl[4]  = '{OP_STEP, QMIN, QMIN, QMIN, QMIN, 0, 0, 0, 0, 1'b0, 0};
    dir_tbl[5]  = '{OP_LOAD, 0, 0, 0, 0, TBL_SHARE, 4'd15, 3'd7, QMIN, 1'b0, 0};
    dir_tbl[6]  = '{OP_LOAD, 0, 0, 0, 0, TBL_IMPACT, 4'd15, 3'd7, QMIN, 1'b0, 0};
    dir_tbl[7]  = '{OP_LOAD, 0, 0, 0, 0, TBL_PROP, 4'd15, 3'd7, QMIN, 1'b0, 0};
    dir_tbl[8]  = '{OP_NOP, QMAX, QMIN, QMAX, QMIN, 2'd3, 4'd15, 3'd7, QMAX, 1'b0, 0};
    dir_tbl[9]  = '{OP_STEP, 32'sd65536, -32'sd65536, 32'sd1, -32'sd1, 0, 0, 0, 0, 1'b0, 0};
    dir_tbl[10] = '{OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0};
    dir_tbl[11] = '{OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, QMAX};
    dir_tbl[12] = '{OP_LOAD, 0, 0, 0, 0, TBL_STEADY, 4'd15, 3'd0, QMIN, 1'b0, 0};
    dir_tbl[13] = '{OP_LOAD, 0, 0, 0, 0, TBL_SHARE, 4'd7, 3'd0, QMAX, 1'b0, 0};
    dir_tbl[14] = '{OP_STEP, QMIN, QMAX, 0, 32'sd32768, 0, 0, 0, 0, 1'b0, 0};
    dir_tbl[15] = '{OP_STEP, 32'sd12345, -32'sd777, 32'sd65536, 0, 0, 0, 0, 0, 1'b0, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every table entry is written before the first step reads it.
    it = '{OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0};
    for (int j = 0; j < NV; j++) begin
      for (int k = 0; k < NS; k++) begin
        it.sel = TBL_PROP; it.r = 4'(j); it.c = 3'(k);
        it.v = $signed($urandom_range(32767)) - 32'sd16384;
        send_item(it);
        if (k < NK) begin
          it.sel = TBL_IMPACT;
          it.v = $signed($urandom_range(131071)) - 32'sd65536;
          send_item(it);
        end
      end
      it.sel = TBL_STEADY; it.r = 4'(j); it.c = '0; it.v = rand_q();
      send_item(it);
      if (j < NS) begin
        it.sel = TBL_SHARE; it.v = $signed($urandom_range(131071)) - 32'sd65536;
        send_item(it);
      end
    end

    send_idle = 14; recv_idle = 63;
    foreach (dir_tbl[i]) send_item(dir_tbl[i]);
    drain_all();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin
          write_reg(REG_STATE_OFFSET, $urandom_range(15));
          write_reg(REG_SHARE_SCALE, rand_q());
          write_reg(REG_SHARE_OFFSET, rand_q());
        end
        1: begin
          write_reg(REG_STATE_OFFSET, 32'd8);
          write_reg(REG_SHARE_SCALE, QMAX);
          write_reg(REG_SHARE_OFFSET, QMIN);
        end
        2: begin
          write_reg(REG_STATE_OFFSET, 32'd15);
          write_reg(REG_SHARE_SCALE, QMIN);
          write_reg(REG_SHARE_OFFSET, QMAX);
        end
        default: begin
          write_reg(REG_STATE_OFFSET, 32'd0);
          write_reg(REG_SHARE_SCALE, 32'sd65536);
          write_reg(REG_SHARE_OFFSET, 32'd0);
        end
      endcase
      if (ph == 4) begin send_idle = 63; recv_idle = 14; end
      if (ph == 8) begin send_idle = 0; recv_idle = 0; end
      if (ph == 2 || ph == 9) begin
        hold_len = 400;
        hold_seq++;
      end
      for (int n = 0; n < 22; n++) send_item(rand_item());
      drain_all();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- linear_state_space_sim_step.f -----
+incdir+hw/rtl
hw/rtl/lssm_pkg.sv
hw/rtl/lssm_lane.sv
hw/rtl/lssm_merge.sv
hw/rtl/linear_state_space_sim_step.sv
hw/rtl/lssm_checker.sv
tb/tb_linear_state_space_sim_step.sv
